// ===== rtl/assert_macros.svh =====
// Assertion macros used by the renderer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clk edge outside reset.
`define OSDG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at each rising clk edge outside reset.
`define OSDG_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/osdg_pkg.sv =====
// Package with constants, register codes and port types of the OSD glyph renderer.
`timescale 1ns / 1ps

package osdg_pkg;

	localparam int LINE_HEIGHT   = 16;
	localparam int CELL_WIDTH    = 8;
	localparam int WIDE_HEIGHT   = 16;
	localparam int WIDE_WIDTH    = 16;
	localparam int NARROW_HEIGHT = 16;
	localparam int NARROW_WIDTH  = 8;

	localparam int LINE_SHIFT = $clog2(LINE_HEIGHT);
	localparam int CELL_SHIFT = $clog2(CELL_WIDTH);

	localparam int GLYPH_ROWS = WIDE_HEIGHT;
	localparam int ROW_W      = $clog2(GLYPH_ROWS);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

	localparam int NARROW_DEPTH = 1536;
	localparam int WIDE_DEPTH   = 282752;
	localparam int WIDE_WORDS   = WIDE_DEPTH / 2;
	localparam int NARROW_AW    = $clog2(NARROW_DEPTH);
	localparam int WIDE_AW      = $clog2(WIDE_WORDS);
	localparam int GB_ROW_LEN   = 94;
	localparam int WIDE_GLYPHS  = GB_ROW_LEN * GB_ROW_LEN;
	localparam int GLYPH_W      = WIDE_AW - ROW_W;

	localparam int FONT_ADDR_W = 19;
	localparam int BYTE_W      = 8;
	localparam int COLOR_W     = 32;
	localparam int CURSOR_W    = 8;
	localparam int DIM_W       = 12;
	localparam int PIX_W       = 22;
	localparam int BITS_W      = 16;
	localparam int NPIX_W      = 5;

	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 112;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0a;
	localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] NARROW_FIRST = 8'h20;
	localparam logic [BYTE_W:0]   GB_FIRST     = 9'h0a1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHAR_COLOR    = 3'd0,
		REG_BACK_COLOR    = 3'd1,
		REG_START_LINE    = 3'd2,
		REG_START_COL     = 3'd3,
		REG_BITMAP_WIDTH  = 3'd4,
		REG_BITMAP_HEIGHT = 3'd5,
		REG_SKIP_SPACES   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                   en;
		logic                   bank;
		logic [FONT_ADDR_W-1:0] addr;
		logic [BYTE_W-1:0]      data;
	} font_wr_t;

	typedef struct packed {
		logic               en;
		logic               wide;
		logic [WIDE_AW-1:0] addr;
	} font_rd_t;

endpackage

// ===== rtl/osd_text_glyph_renderer_unit.sv =====
// Top level of the OSD text glyph renderer: decode, cursor, row sequencer and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// s_axis carries font writes (tuser[0] = 0) and text bytes (tuser[0] = 1).
// A font write stores one byte into the narrow or wide font; a write beyond the
// font depth is dropped. A control byte (NUL, newline, skipped space) only moves
// the cursor; a GB2312 lead byte is held for the next text byte. A printable byte
// or a GB2312 trail byte on a visible line produces 16 row transfers on m_axis,
// tlast on the final row. Per glyph: accept, a setup state for the glyph address
// and the pixel base product, then one font read per row. The first row then
// passes the read stage and the output register; the single font memory read
// port sets the row rate of one row per cycle while m_axis does not stall.
// cfg writes take effect at once (cfg_ready is always high); write them only
// while the block is idle and every row has been taken.
// m_axis stalls hold the output register and the read stage; the row sequencer
// waits with them, so no row is lost. s_axis_tready is low until the last row is issued.
// Reset clears the cursor, the pending lead byte and the registers to defaults;
// the font memories hold no defined content until written.
module osd_text_glyph_renderer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// font_addr[18:0], font_byte[26:19], text_byte[34:27], zero fill
	input  logic [osdg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// func[0], font_bank[1]
	input  logic [osdg_pkg::IN_USER_W-1:0]    s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pixel_index[21:0], row_bits[37:22], row_pixels[42:38], fore_color[74:43],
	// fill_color[106:75], zero fill
	output logic [osdg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [osdg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [osdg_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import osdg_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ROWS
	} state_t;

	function automatic logic [CURSOR_W-1:0] sat_add(logic [CURSOR_W-1:0] v, logic [1:0] d);
		logic [CURSOR_W:0] s;
		s = {1'b0, v} + (CURSOR_W + 1)'(d);
		return s[CURSOR_W] ? {CURSOR_W{1'b1}} : s[CURSOR_W-1:0];
	endfunction

	state_t state_q;

	logic [COLOR_W-1:0]  char_color_q;
	logic [COLOR_W-1:0]  back_color_q;
	logic [CURSOR_W-1:0] start_line_q;
	logic [CURSOR_W-1:0] start_col_q;
	logic [DIM_W-1:0]    bitmap_width_q;
	logic [DIM_W-1:0]    bitmap_height_q;
	logic                skip_spaces_q;

	logic [CURSOR_W-1:0] col_q;
	logic [CURSOR_W-1:0] line_q;
	logic [BYTE_W-1:0]   lead_q;
	logic                pending_q;

	logic                wide_q;
	logic [BYTE_W-1:0]   trail_q;
	logic [CURSOR_W:0]   lsum_q;
	logic [CURSOR_W:0]   csum_q;
	logic [GLYPH_W-1:0]  glyph_q;
	logic                zero_q;
	logic [ROW_W-1:0]    row_q;
	logic [PIX_W-1:0]    pix_q;

	logic                valid_s1;
	logic                zero_s1;
	logic                wide_s1;
	logic                last_s1;
	logic [PIX_W-1:0]    pix_s1;

	logic                out_valid_q;
	logic                out_wide_q;
	logic                out_last_q;
	logic [PIX_W-1:0]    out_pix_q;
	logic [BITS_W-1:0]   out_bits_q;

	logic                in_fire;
	logic                in_func;
	logic                in_bank;
	logic [FONT_ADDR_W-1:0] in_font_addr;
	logic [BYTE_W-1:0]   in_font_byte;
	logic [BYTE_W-1:0]   in_text;
	logic                visible;
	logic                is_skip;
	logic                narrow_draw;
	logic                adv;
	logic                issue;

	logic signed [BYTE_W:0]  sec_m1;
	logic signed [BYTE_W:0]  pot_m1;
	logic signed [15:0]      wide_idx;
	logic                    wide_ok;
	logic                    narrow_ok;
	logic [6:0]              narrow_idx;
	logic [DIM_W+CURSOR_W+LINE_SHIFT:0] pix_prod;
	logic [CURSOR_W+LINE_SHIFT:0]       line_px;
	logic [PIX_W-1:0]        pix_base;
	logic [NPIX_W-1:0]       row_pixels;

	font_wr_t            font_wr;
	font_rd_t            font_rd;
	logic [BITS_W-1:0]   rd_data;

	assign in_fire      = s_axis_tvalid && s_axis_tready;
	assign in_func      = s_axis_tuser[0];
	assign in_bank      = s_axis_tuser[1];
	assign in_font_addr = s_axis_tdata[18:0];
	assign in_font_byte = s_axis_tdata[26:19];
	assign in_text      = s_axis_tdata[34:27];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;

	assign visible     = line_q < bitmap_height_q[DIM_W-1:LINE_SHIFT];
	assign is_skip     = skip_spaces_q && (in_text == CHAR_SPACE);
	assign narrow_draw = (in_text != CHAR_NUL) && (in_text != CHAR_NEWLINE) && !is_skip
		&& !in_text[BYTE_W-1];

	assign sec_m1     = $signed({1'b0, lead_q}) - $signed(GB_FIRST);
	assign pot_m1     = $signed({1'b0, trail_q}) - $signed(GB_FIRST);
	assign wide_idx   = 16'(16'(sec_m1) * 16'(GB_ROW_LEN) + 16'(pot_m1));
	assign wide_ok    = !wide_idx[15] && (wide_idx[14:0] < 15'(WIDE_GLYPHS));
	assign narrow_ok  = trail_q >= NARROW_FIRST;
	assign narrow_idx = 7'(trail_q - NARROW_FIRST);

	assign line_px  = {lsum_q, {LINE_SHIFT{1'b0}}};
	assign pix_prod = bitmap_width_q * line_px;
	assign pix_base = pix_prod[PIX_W-1:0] + PIX_W'({csum_q, {CELL_SHIFT{1'b0}}});

	assign adv   = !out_valid_q || m_axis_tready;
	assign issue = (state_q == ST_ROWS) && adv;

	assign font_wr.en   = in_fire && !in_func;
	assign font_wr.bank = in_bank;
	assign font_wr.addr = in_font_addr;
	assign font_wr.data = in_font_byte;

	assign font_rd.en   = issue && !zero_q;
	assign font_rd.wide = wide_q;
	assign font_rd.addr = {glyph_q, row_q};

	osdg_font_store u_font_store (
		.clk     (clk),
		.wr      (font_wr),
		.rd      (font_rd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_color_q    <= {COLOR_W{1'b1}};
			back_color_q    <= '0;
			start_line_q    <= '0;
			start_col_q     <= '0;
			bitmap_width_q  <= DIM_W'(720);
			bitmap_height_q <= DIM_W'(576);
			skip_spaces_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CHAR_COLOR:    char_color_q    <= cfg_data;
				REG_BACK_COLOR:    back_color_q    <= cfg_data;
				REG_START_LINE:    start_line_q    <= cfg_data[CURSOR_W-1:0];
				REG_START_COL:     start_col_q     <= cfg_data[CURSOR_W-1:0];
				REG_BITMAP_WIDTH:  bitmap_width_q  <= cfg_data[DIM_W-1:0];
				REG_BITMAP_HEIGHT: bitmap_height_q <= cfg_data[DIM_W-1:0];
				REG_SKIP_SPACES:   skip_spaces_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			line_q      <= '0;
			lead_q      <= '0;
			pending_q   <= 1'b0;
			row_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && in_func) begin
						trail_q <= in_text;
						lsum_q  <= {1'b0, line_q} + {1'b0, start_line_q};
						csum_q  <= {1'b0, col_q} + {1'b0, start_col_q};
						priority if (pending_q) begin
							pending_q <= 1'b0;
							wide_q    <= 1'b1;
							col_q     <= sat_add(col_q, 2'd2);
							if (visible) begin
								state_q <= ST_SETUP;
							end
						end else if (in_text == CHAR_NUL) begin
							col_q  <= '0;
							line_q <= '0;
						end else if (in_text == CHAR_NEWLINE) begin
							col_q  <= '0;
							line_q <= sat_add(line_q, 2'd1);
						end else if (is_skip) begin
							col_q <= sat_add(col_q, 2'd1);
						end else if (in_text[BYTE_W-1]) begin
							lead_q    <= in_text;
							pending_q <= 1'b1;
						end else begin
							wide_q <= 1'b0;
							col_q  <= sat_add(col_q, 2'd1);
							if (visible && narrow_draw) begin
								state_q <= ST_SETUP;
							end
						end
					end
				end
				ST_SETUP: begin
					glyph_q <= wide_q ? wide_idx[GLYPH_W-1:0] : GLYPH_W'(narrow_idx);
					zero_q  <= wide_q ? !wide_ok : !narrow_ok;
					pix_q   <= pix_base;
					row_q   <= '0;
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					if (issue) begin
						row_q <= row_q + 1'b1;
						pix_q <= pix_q + PIX_W'(bitmap_width_q);
						if (row_q == ROW_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// read stage: advance with the output register, hold on stall
			if (adv) begin
				valid_s1 <= issue;
				if (issue) begin
					zero_s1 <= zero_q;
					wide_s1 <= wide_q;
					last_s1 <= (row_q == ROW_LAST);
					pix_s1  <= pix_q;
				end
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					out_pix_q  <= pix_s1;
					out_bits_q <= zero_s1 ? '0 : rd_data;
					out_wide_q <= wide_s1;
					out_last_q <= last_s1;
				end
			end
		end
	end

	assign row_pixels    = out_wide_q ? NPIX_W'(WIDE_WIDTH) : NPIX_W'(NARROW_WIDTH);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {5'b0, back_color_q, char_color_q, row_pixels, out_bits_q,
		out_pix_q};

	`OSDG_ASSERT_NXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(pix_s1) && $stable(last_s1), "read stage lost a row under stall")
	`OSDG_ASSERT_NXT(a_last_row_idle, issue && (row_q == ROW_LAST), state_q == ST_IDLE, "sequencer did not finish after last row")
	`OSDG_ASSERT_IMP(a_row_width, m_axis_tvalid, (m_axis_tdata[42:38] == 5'd8) || (m_axis_tdata[42:38] == 5'd16), "row width is neither narrow nor wide")

endmodule

// ===== rtl/osdg_font_store.sv =====
// Narrow and wide font memories with one byte write port and one registered row read port.
`timescale 1ns / 1ps

module osdg_font_store (
	input  logic                     clk,
	input  osdg_pkg::font_wr_t       wr,
	input  osdg_pkg::font_rd_t       rd,
	output logic [osdg_pkg::BITS_W-1:0] rd_data
);
	import osdg_pkg::*;

	logic [BYTE_W-1:0]        narrow_mem [NARROW_DEPTH];
	logic [1:0][BYTE_W-1:0]   wide_mem   [WIDE_WORDS];
	logic [BYTE_W-1:0]        narrow_rd_q;
	logic [1:0][BYTE_W-1:0]   wide_rd_q;
	logic                     wide_sel_q;

	// even byte address holds the left half of a wide row
	always_ff @(posedge clk) begin
		if (wr.en && !wr.bank && (wr.addr < FONT_ADDR_W'(NARROW_DEPTH))) begin
			narrow_mem[wr.addr[NARROW_AW-1:0]] <= wr.data;
		end
		if (wr.en && wr.bank && (wr.addr < FONT_ADDR_W'(WIDE_DEPTH))) begin
			wide_mem[wr.addr[FONT_ADDR_W-1:1]][!wr.addr[0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			wide_sel_q <= rd.wide;
			if (rd.wide) begin
				wide_rd_q <= wide_mem[rd.addr];
			end else begin
				narrow_rd_q <= narrow_mem[rd.addr[NARROW_AW-1:0]];
			end
		end
	end

	assign rd_data = wide_sel_q ? wide_rd_q : {narrow_rd_q, {BYTE_W{1'b0}}};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the OSD glyph renderer: font upload, text rendering and row checks.
module tb;
	import osdg_pkg::*;

	localparam bit FN_FONT     = 1'b0;
	localparam bit FN_TEXT     = 1'b1;
	localparam bit BANK_NARROW = 1'b0;
	localparam bit BANK_WIDE   = 1'b1;
	localparam int GB_BASE     = 'ha0;
	localparam int LEAD_MIN    = 'h80;
	localparam int CURSOR_MAX  = 255;
	localparam int GLYPH_BYTES = WIDE_HEIGHT * 2;
	localparam int NARROW_GLYPH_BYTES = NARROW_HEIGHT;
	localparam int IDLE_LIMIT  = 5000;
	localparam int SETTLE      = 40;
	localparam int HOLD_CYCLES = 400;

	localparam int BITS_LO = PIX_W;
	localparam int NPIX_LO = BITS_LO + BITS_W;
	localparam int FORE_LO = NPIX_LO + NPIX_W;
	localparam int FILL_LO = FORE_LO + COLOR_W;

	typedef struct packed {
		logic                   func;
		logic                   bank;
		logic [FONT_ADDR_W-1:0] addr;
		logic [BYTE_W-1:0]      fbyte;
		logic [BYTE_W-1:0]      text;
	} osd_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pix;
		logic [BITS_W-1:0]  bits;
		logic [NPIX_W-1:0]  npix;
		logic [COLOR_W-1:0] fore;
		logic [COLOR_W-1:0] fill;
		logic               last;
	} glyph_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	osd_in_t    pending_bytes[$];
	osd_in_t    held_item;
	glyph_row_t expected_rows[$];
	int         mismatches = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_requests = 0;
	int         holds_served;
	int         hold_left;
	int         quiet;

	// shadow of the block
	logic [7:0]  narrow_rom [NARROW_DEPTH];
	logic [7:0]  wide_rom [WIDE_DEPTH];
	int          cur_col, cur_line;
	logic [7:0]  lead_val;
	bit          lead_wait;
	logic [31:0] char_c, back_c;
	int          line0, col0, bm_width, bm_height;
	bit          skip_sp;

	// stimulus bookkeeping: which glyphs are fully loaded
	bit wide_set [WIDE_DEPTH];
	int wide_fill [WIDE_GLYPHS];
	int loaded_glyphs[$];
	int narrow_glyphs[$];
	bit gen_lead_wait;

	osd_text_glyph_renderer_unit u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int bump(int v, int d);
		return (v + d > CURSOR_MAX) ? CURSOR_MAX : v + d;
	endfunction

	function automatic logic [7:0] font_peek(bit wide, longint a);
		if (a < 0)
			return 8'h00;
		if (wide)
			return (a < WIDE_DEPTH) ? wide_rom[int'(a)] : 8'h00;
		return (a < NARROW_DEPTH) ? narrow_rom[int'(a)] : 8'h00;
	endfunction

	task automatic emit_rows(bit wide, longint idx);
		int h, w, bpr;
		longint base, a, pix;
		logic [15:0] raw, keep;
		glyph_row_t row;
		h = wide ? WIDE_HEIGHT : NARROW_HEIGHT;
		w = wide ? WIDE_WIDTH : NARROW_WIDTH;
		bpr = (w + 7) / 8;
		keep = 16'hffff << (BITS_W - w);
		if (cur_line >= bm_height / LINE_HEIGHT)
			return;
		base = idx * h * bpr;
		for (int r = 0; r < h; r++) begin
			a = (idx < 0) ? -1 : base + r * bpr;
			raw = {font_peek(wide, a), (bpr > 1 && a >= 0) ? font_peek(wide, a + 1) : 8'h00};
			pix = longint'(bm_width) * (LINE_HEIGHT * (cur_line + line0) + r)
				+ CELL_WIDTH * (cur_col + col0);
			row.pix = pix[PIX_W-1:0];
			row.bits = raw & keep;
			row.npix = NPIX_W'(w);
			row.fore = char_c;
			row.fill = back_c;
			row.last = (r == h - 1);
			expected_rows.push_back(row);
		end
	endtask

	task automatic render_byte(osd_in_t it);
		longint idx;
		if (it.func == FN_FONT) begin
			if (it.bank == BANK_NARROW) begin
				if (it.addr < NARROW_DEPTH)
					narrow_rom[it.addr] = it.fbyte;
			end else if (it.addr < WIDE_DEPTH) begin
				wide_rom[it.addr] = it.fbyte;
			end
			return;
		end
		if (lead_wait) begin
			idx = GB_ROW_LEN * (longint'(lead_val) - GB_BASE - 1) + (longint'(it.text) - GB_BASE - 1);
			lead_wait = 1'b0;
			emit_rows(1'b1, idx);
			cur_col = bump(cur_col, 2);
		end else if (it.text == CHAR_NUL) begin
			cur_col = 0;
			cur_line = 0;
		end else if (it.text == CHAR_NEWLINE) begin
			cur_col = 0;
			cur_line = bump(cur_line, 1);
		end else if (skip_sp && it.text == CHAR_SPACE) begin
			cur_col = bump(cur_col, 1);
		end else if (it.text[7]) begin
			lead_val = it.text;
			lead_wait = 1'b1;
		end else begin
			emit_rows(1'b0, longint'(it.text) - longint'(NARROW_FIRST));
			cur_col = bump(cur_col, 1);
		end
	endtask

	function automatic void apply_reg(cfg_reg_t r, logic [31:0] d);
		case (r)
			REG_CHAR_COLOR:    char_c = d;
			REG_BACK_COLOR:    back_c = d;
			REG_START_LINE:    line0 = int'(d[CURSOR_W-1:0]);
			REG_START_COL:     col0 = int'(d[CURSOR_W-1:0]);
			REG_BITMAP_WIDTH:  bm_width = int'(d[DIM_W-1:0]);
			REG_BITMAP_HEIGHT: bm_height = int'(d[DIM_W-1:0]);
			REG_SKIP_SPACES:   skip_sp = d[0];
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void send_font(bit bank, int addr, int b);
		osd_in_t it;
		it.func = FN_FONT;
		it.bank = bank;
		it.addr = FONT_ADDR_W'(addr);
		it.fbyte = BYTE_W'(b);
		it.text = BYTE_W'($urandom);
		if (bank == BANK_WIDE && addr < WIDE_DEPTH && !wide_set[addr]) begin
			wide_set[addr] = 1'b1;
			wide_fill[addr / GLYPH_BYTES]++;
		end
		pending_bytes.push_back(it);
	endfunction

	function automatic void send_text(int c);
		osd_in_t it;
		it.func = FN_TEXT;
		it.bank = 1'($urandom);
		it.addr = FONT_ADDR_W'($urandom);
		it.fbyte = BYTE_W'($urandom);
		it.text = BYTE_W'(c);
		if (gen_lead_wait)
			gen_lead_wait = 1'b0;
		else if (c >= LEAD_MIN)
			gen_lead_wait = 1'b1;
		pending_bytes.push_back(it);
	endfunction

	// a pair may only select a wide glyph that is fully loaded or lies outside the font
	function automatic bit trail_ok(int lead, int t);
		longint idx;
		idx = GB_ROW_LEN * (lead - GB_BASE - 1) + (t - GB_BASE - 1);
		return idx < 0 || idx >= WIDE_GLYPHS || wide_fill[int'(idx)] == GLYPH_BYTES;
	endfunction

	function automatic int send_pair(int g, bit split);
		send_text(GB_BASE + 1 + g / GB_ROW_LEN);
		if (split)
			send_font(BANK_NARROW, $urandom_range(NARROW_DEPTH - 1), $urandom_range(255));
		send_text(GB_BASE + 1 + g % GB_ROW_LEN);
		return 2 + split;
	endfunction

	function automatic void send_random_pair();
		int lead, t;
		bit found;
		do begin
			lead = $urandom_range(255, LEAD_MIN);
			found = 1'b0;
			for (int k = 0; k < 256; k++)
				if (trail_ok(lead, k))
					found = 1'b1;
		end while (!found);
		send_text(lead);
		do
			t = $urandom_range(255);
		while (!trail_ok(lead, t));
		send_text(t);
	endfunction

	function automatic int random_step();
		int r;
		r = $urandom_range(99);
		if (r < 12) begin
			if ($urandom_range(1))
				send_font(1'($urandom_range(1)), $urandom_range(2**FONT_ADDR_W - 1),
					$urandom_range(255));
			else if ($urandom_range(1))
				send_font(BANK_NARROW, $urandom_range(NARROW_DEPTH - 1), $urandom_range(255));
			else
				send_font(BANK_WIDE, loaded_glyphs[$urandom_range(loaded_glyphs.size() - 1)]
					* GLYPH_BYTES + $urandom_range(GLYPH_BYTES - 1), $urandom_range(255));
			return 1;
		end
		if (r < 20)
			send_text(int'(CHAR_NEWLINE));
		else if (r < 24)
			send_text(int'(CHAR_NUL));
		else if (r < 31)
			send_text(int'(CHAR_SPACE));
		else if (r < 34)
			send_text($urandom_range(NARROW_FIRST - 1, 1));
		else if (r < 60)
			send_text(int'(NARROW_FIRST)
				+ narrow_glyphs[$urandom_range(narrow_glyphs.size() - 1)]);
		else if (r < 88)
			return send_pair(loaded_glyphs[$urandom_range(loaded_glyphs.size() - 1)],
				$urandom_range(9) == 0);
		else begin
			send_random_pair();
			return 2;
		end
		return 1;
	endfunction

	task automatic random_items(int n);
		int made;
		made = 0;
		while (made < n)
			made += random_step();
	endtask

	task automatic write_reg(cfg_reg_t r, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(r, d);
	endtask

	task automatic set_config(logic [31:0] fc, logic [31:0] bc, int sl, int sc, int w, int h, bit sk);
		write_reg(REG_CHAR_COLOR, fc);
		write_reg(REG_BACK_COLOR, bc);
		write_reg(REG_START_LINE, sl);
		write_reg(REG_START_COL, sc);
		write_reg(REG_BITMAP_WIDTH, w);
		write_reg(REG_BITMAP_HEIGHT, h);
		write_reg(REG_SKIP_SPACES, 32'(sk));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() != 0 || s_axis_tvalid || expected_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				render_byte(held_item);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					held_item = pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {{(IN_DATA_W - FONT_ADDR_W - 2 * BYTE_W){1'b0}},
						held_item.text, held_item.fbyte, held_item.addr};
					s_axis_tuser <= {held_item.bank, held_item.func};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			holds_served <= 0;
		end else if (holds_served != hold_requests) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// row checker
	always @(posedge clk) begin
		glyph_row_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rows.size() == 0) begin
				$error("row transfer with no glyph row pending");
				mismatches++;
			end else begin
				want = expected_rows.pop_front();
				check_field("pixel_index", 32'(want.pix), 32'(m_axis_tdata[0 +: PIX_W]));
				check_field("row_bits", 32'(want.bits), 32'(m_axis_tdata[BITS_LO +: BITS_W]));
				check_field("row_pixels", 32'(want.npix), 32'(m_axis_tdata[NPIX_LO +: NPIX_W]));
				check_field("fore_color", want.fore, m_axis_tdata[FORE_LO +: COLOR_W]);
				check_field("fill_color", want.fill, m_axis_tdata[FILL_LO +: COLOR_W]);
				check_field("last", 32'(want.last), 32'(m_axis_tlast));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= IDLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		char_c = 32'hffff_ffff;
		back_c = '0;
		line0 = 0;
		col0 = 0;
		bm_width = 720;
		bm_height = 576;
		skip_sp = 1'b0;
		cur_col = 0;
		cur_line = 0;
		lead_val = '0;
		lead_wait = 1'b0;
		gen_lead_wait = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load the space glyph, the last narrow glyph and the first and last wide glyphs
		set_config(32'hffff_ffff, 32'h0, 0, 0, 720, 576, 1'b0);
		narrow_glyphs = '{0, LEAD_MIN - 1 - int'(NARROW_FIRST)};
		foreach (narrow_glyphs[i])
			for (int b = 0; b < NARROW_GLYPH_BYTES; b++)
				send_font(BANK_NARROW, narrow_glyphs[i] * NARROW_GLYPH_BYTES + b,
					$urandom_range(255));
		loaded_glyphs = '{0, WIDE_GLYPHS - 1};
		foreach (loaded_glyphs[i])
			for (int b = 0; b < GLYPH_BYTES; b++)
				send_font(BANK_WIDE, loaded_glyphs[i] * GLYPH_BYTES + b, $urandom_range(255));
		wait_idle();

		// store edges, glyph extremes, out-of-font glyphs, odd trail bytes
		send_font(BANK_NARROW, NARROW_DEPTH, 'h55);
		send_font(BANK_WIDE, WIDE_DEPTH, 'haa);
		send_font(BANK_NARROW, 2**FONT_ADDR_W - 1, 'hff);
		send_font(BANK_WIDE, 2**FONT_ADDR_W - 1, 'h00);
		send_text(int'(CHAR_SPACE));
		send_text(LEAD_MIN - 1);
		send_text(1);
		send_text(int'(CHAR_NEWLINE));
		void'(send_pair(0, 1'b0));
		void'(send_pair(WIDE_GLYPHS - 1, 1'b0));
		void'(send_pair(0, 1'b1));
		send_text(LEAD_MIN);
		send_text('hff);
		send_text('hff);
		send_text('hff);
		send_text(GB_BASE + 1);
		send_text(int'(CHAR_NUL));
		send_text(GB_BASE + 1);
		send_text(int'(CHAR_NEWLINE));
		send_text(int'(CHAR_NUL));
		send_text(LEAD_MIN - 1);
		wait_idle();

		set_config(32'h0, 32'hffff_ffff, CURSOR_MAX, CURSOR_MAX, 1, 2047, 1'b1);
		send_text(int'(CHAR_SPACE));
		random_items(10);
		wait_idle();

		set_config($urandom, $urandom, 0, 0, 2048, LINE_HEIGHT, 1'b0);
		send_idle_pct = 60;
		random_items(10);
		wait_idle();

		set_config($urandom, $urandom, $urandom_range(CURSOR_MAX), $urandom_range(CURSOR_MAX),
			$urandom_range(2048, 1), $urandom_range(2047, 256), 1'($urandom_range(1)));
		send_idle_pct = 0;
		recv_stall_pct = 60;
		hold_requests++;
		random_items(12);
		wait_idle();

		set_config($urandom, $urandom, $urandom_range(CURSOR_MAX), $urandom_range(CURSOR_MAX),
			$urandom_range(2048, 1), $urandom_range(2048, 1), 1'($urandom_range(1)));
		send_idle_pct = 27;
		recv_stall_pct = 27;
		random_items(10);
		wait_idle();

		// a bitmap too short for a single text line, then a space on a tall bitmap
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config($urandom, $urandom, 0, 0, 720, 1, 1'b0);
		send_text(LEAD_MIN - 1);
		void'(send_pair(0, 1'b0));
		wait_idle();
		set_config($urandom, $urandom, 0, 0, 720, 2048, 1'b0);
		send_text(int'(CHAR_SPACE));
		wait_idle();

		if (mismatches == 0 && expected_rows.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
